// ----- hw/rtl/html_tag_strip_entity_decode_top_assert.svh -----
// Assertion macros shared by the tag stripper RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_TOP_ASSERT_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTSED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTSED_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/htsed_pkg.sv -----
// Package for the tag stripper: entity tables, character codes, FSM state type
// and the command/status structs between controller and datapath. No dependencies.
package htsed_pkg;

    localparam int HOLD_MAX    = 5;
    localparam int ENT_COUNT   = 5;
    localparam int ENT_MAX_LEN = 6;

    localparam logic [7:0] CHAR_LT  = 8'h3C;
    localparam logic [7:0] CHAR_GT  = 8'h3E;
    localparam logic [7:0] CHAR_AMP = 8'h26;

    // &amp; &lt; &gt; &quot; &nbsp; (unused tail positions are zero)
    localparam logic [7:0] ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
    };
    localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
    localparam logic [7:0] ENT_VALUE [ENT_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_STEP,
        S_FIN,
        S_NULL
    } state_t;

    typedef struct packed {
        logic accept;
        logic pre_emit;
        logic step;
        logic fin_emit;
        logic null_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic pre_flush;
        logic step_emit;
        logic step_held_zero;
        logic k_last;
        logic out_free;
        logic fin;
        logic emitted;
    } dp_sts_t;

endpackage

// ----- hw/rtl/htsed_ctrl.sv -----
// Sequencer for the tag stripper: accepts an item, flushes a broken entity
// prefix, applies the byte, then flushes at end of text or emits an empty end result. Uses htsed_pkg.
module htsed_ctrl
    import htsed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  dp_sts_t sts,
    output logic    in_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (!sts.pre_flush || (sts.out_free && sts.k_last))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!sts.step_emit || sts.out_free)
                begin
                    if (!sts.fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!sts.step_held_zero)
                    begin
                        state_next = S_FIN;
                    end
                    else if (!sts.emitted && !sts.step_emit)
                    begin
                        state_next = S_NULL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free && sts.k_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_NULL:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_PRE:
            begin
                cmd.pre_emit = sts.pre_flush && sts.out_free;
            end
            S_STEP:
            begin
                cmd.step = !sts.step_emit || sts.out_free;
            end
            S_FIN:
            begin
                cmd.fin_emit = sts.out_free;
            end
            S_NULL:
            begin
                cmd.null_emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/htsed_dpath.sv -----
// Datapath for the tag stripper: item latch, tag/hold state, entity matcher
// and the output register. Uses htsed_pkg and the assertion macro header.
`include "html_tag_strip_entity_decode_top_assert.svh"

module htsed_dpath
    import htsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_sts_t    sts,
    input  logic [7:0] in_byte,
    input  logic       has_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_text
);

    logic [7:0] c_reg;
    logic       has_reg;
    logic       fin_reg;
    logic       inside_reg;
    logic [2:0] held_count_reg;
    logic [7:0] held_chars_reg [HOLD_MAX];
    logic [2:0] k_reg;
    logic       emitted_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg;
    logic       out_end_reg;

    logic       any_match;
    logic       match_full;
    logic [7:0] match_val;
    logic       held_path;
    logic       ent_hit;
    logic       plain;
    logic       is_lt;
    logic       is_gt;
    logic       is_amp;
    logic       lit_out;
    logic       pre_flush;
    logic [2:0] base_held;
    logic       step_emit;
    logic [7:0] step_byte;
    logic [2:0] step_held_next;
    logic       step_inside_next;
    logic       k_last;
    logic       out_free;
    logic       out_load;
    logic [7:0] out_byte_next;
    logic       out_bv_next;
    logic       out_end_next;
    logic       end_pre;

    // Candidate = held bytes followed by the new byte, checked against each entity.
    always_comb
    begin
        logic ok;
        any_match  = 1'b0;
        match_full = 1'b0;
        match_val  = '0;
        for (int e = ENT_COUNT - 1; e >= 0; e--)
        begin
            ok = (held_count_reg < ENT_LEN[e]);
            for (int j = 0; j < HOLD_MAX; j++)
            begin
                if (3'(j) < held_count_reg)
                begin
                    ok = ok && (held_chars_reg[j] == ENT_TEXT[e][j]);
                end
            end
            for (int j = 0; j < ENT_MAX_LEN; j++)
            begin
                if (3'(j) == held_count_reg)
                begin
                    ok = ok && (c_reg == ENT_TEXT[e][j]);
                end
            end
            if (ok)
            begin
                any_match  = 1'b1;
                match_full = ((held_count_reg + 3'd1) == ENT_LEN[e]);
                match_val  = ENT_VALUE[e];
            end
        end
    end

    assign is_lt     = (c_reg == CHAR_LT);
    assign is_gt     = (c_reg == CHAR_GT);
    assign is_amp    = (c_reg == CHAR_AMP);
    assign held_path = has_reg && (held_count_reg != 3'd0) && !inside_reg;
    assign ent_hit   = held_path && any_match;
    assign pre_flush = held_path && !any_match;
    assign plain     = has_reg && !ent_hit;
    assign base_held = pre_flush ? 3'd0 : held_count_reg;
    assign lit_out   = !is_lt && !is_gt && !inside_reg;

    assign step_emit = ent_hit ? match_full : (plain && lit_out && !is_amp);
    assign step_byte = ent_hit ? match_val : c_reg;

    always_comb
    begin
        if (!has_reg)
        begin
            step_held_next = held_count_reg;
        end
        else if (ent_hit)
        begin
            step_held_next = match_full ? 3'd0 : held_count_reg + 3'd1;
        end
        else
        begin
            step_held_next = (lit_out && is_amp) ? 3'd1 : base_held;
        end
    end

    always_comb
    begin
        step_inside_next = inside_reg;
        if (plain && is_lt)
        begin
            step_inside_next = 1'b1;
        end
        else if (plain && is_gt)
        begin
            step_inside_next = 1'b0;
        end
    end

    assign k_last   = (k_reg == held_count_reg - 3'd1);
    assign out_free = !out_valid_reg || out_ready;
    // last pre-flushed byte ends the text only when the byte itself leaves nothing
    assign end_pre  = fin_reg && k_last && !step_emit && (step_held_next == 3'd0);

    assign sts.pre_flush      = pre_flush;
    assign sts.step_emit      = step_emit;
    assign sts.step_held_zero = (step_held_next == 3'd0);
    assign sts.k_last         = k_last;
    assign sts.out_free       = out_free;
    assign sts.fin            = fin_reg;
    assign sts.emitted        = emitted_reg;

    always_comb
    begin
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        out_bv_next   = out_bv_reg;
        out_end_next  = out_end_reg;
        if (cmd.pre_emit || cmd.fin_emit)
        begin
            out_load      = 1'b1;
            out_byte_next = held_chars_reg[k_reg];
            out_bv_next   = 1'b1;
            out_end_next  = cmd.pre_emit ? end_pre : k_last;
        end
        else if (cmd.step && step_emit)
        begin
            out_load      = 1'b1;
            out_byte_next = step_byte;
            out_bv_next   = 1'b1;
            out_end_next  = fin_reg;
        end
        else if (cmd.null_emit)
        begin
            out_load      = 1'b1;
            out_byte_next = 8'h00;
            out_bv_next   = 1'b0;
            out_end_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            inside_reg     <= 1'b0;
            held_count_reg <= 3'd0;
            k_reg          <= 3'd0;
            emitted_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                has_reg     <= has_byte;
                fin_reg     <= end_of_input;
                k_reg       <= 3'd0;
                emitted_reg <= 1'b0;
            end
            if (out_load)
            begin
                emitted_reg <= 1'b1;
            end
            if (cmd.pre_emit)
            begin
                k_reg <= k_last ? 3'd0 : k_reg + 3'd1;
            end
            if (cmd.step)
            begin
                held_count_reg <= step_held_next;
                inside_reg     <= fin_reg ? 1'b0 : step_inside_next;
            end
            if (cmd.fin_emit)
            begin
                if (k_last)
                begin
                    held_count_reg <= 3'd0;
                    k_reg          <= 3'd0;
                end
                else
                begin
                    k_reg <= k_reg + 3'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            c_reg <= in_byte;
        end
        if (cmd.step && ent_hit && !match_full)
        begin
            held_chars_reg[held_count_reg] <= c_reg;
        end
        else if (cmd.step && plain && lit_out && is_amp)
        begin
            held_chars_reg[0] <= c_reg;
        end
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            out_bv_reg   <= out_bv_next;
            out_end_reg  <= out_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign end_of_text = out_end_reg;

    `HTSED_ASSERT_IMP(a_held_outside_tag, clk, rst_n, held_count_reg != 3'd0, !inside_reg, "held prefix inside a tag")
    `HTSED_ASSERT_IMP(a_pre_flush_range, clk, rst_n, cmd.pre_emit, (held_count_reg != 3'd0) && (k_reg < held_count_reg), "pre-flush index out of range")
    `HTSED_ASSERT_NXT(a_end_clears_state, clk, rst_n, cmd.step && fin_reg && (step_held_next == 3'd0), (held_count_reg == 3'd0) && !inside_reg, "state not cleared at end of text")

endmodule

// ----- hw/rtl/html_tag_strip_entity_decode_top.sv -----
// Each item passes through the sequencer states S_IDLE, S_PRE and S_STEP; its result is registered in S_STEP,
// after any broken entity prefix is flushed from S_PRE, one byte per result. At end of text held bytes flush
// from S_FIN and an empty end result comes from S_NULL. A new item is taken only in S_IDLE.
// The sequencer emits at most one result per cycle into one output register, stalling while it is not free.
// Reset (rst_n low, asynchronous): outside any tag, nothing held, no result pending.
module html_tag_strip_entity_decode_top
    import htsed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tuser,  // [0] has_byte
    input  logic       s_axis_tlast,  // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tuser,  // [0] byte_valid
    output logic       m_axis_tlast   // end_of_text
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    htsed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    htsed_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_byte      (s_axis_tdata),
        .has_byte     (s_axis_tuser),
        .end_of_input (s_axis_tlast),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .byte_valid   (m_axis_tuser),
        .end_of_text  (m_axis_tlast)
    );

endmodule

// ----- test/html_tag_strip_entity_decode_top_test.sv -----
// Self-checking testbench for html_tag_strip_entity_decode_top: tag stripping and entity decoding.
// Drives stream traffic, predicts the text output from a local model; uses htsed_pkg constants.
`timescale 1ns / 100ps

module html_tag_strip_entity_decode_top_test;
    import htsed_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } text_out_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       eoi;
        logic       typed;      // expectation written out below instead of predicted
        logic       typed_out;  // typed row gives one result
        logic [7:0] exp_ch;
        logic       exp_valid;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tuser;   // [0] has_byte
    logic       s_axis_tlast;   // end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tuser;   // [0] byte_valid
    logic       m_axis_tlast;   // end_of_text

    // predictor state
    logic       tag_open;
    int unsigned held_len;
    logic [7:0] held_text [HOLD_MAX];
    text_out_t  text_out_q [$];
    text_out_t  next_exp;

    int unsigned fail_count;
    int unsigned text_items;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off_req;

    // plain text, tag bracket, stray bytes inside a tag, entity prefixes and ends
    stim_row_t directed_rows [0:25] = '{
        '{8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 8'h41, 1'b1},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{8'h01, 1'b1, 1'b0, 1'b1, 1'b1, 8'h01, 1'b1},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
        '{8'h3C, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h78, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h26, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h3E, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h26, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h6D, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h70, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h3B, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h26, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h71, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h75, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h6F, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h74, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h3B, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h26, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h71, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h3C, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h3E, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h26, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h6E, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    html_tag_strip_entity_decode_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void emit_char(input logic [7:0] c, input logic v);
        text_out_t r;
        r.ch    = c;
        r.valid = v;
        r.last  = 1'b0;
        text_out_q.push_back(r);
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < held_len; k++)
            emit_char(held_text[k], 1'b1);
        held_len = 0;
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == CHAR_LT)
            tag_open = 1'b1;
        else if (c == CHAR_GT)
            tag_open = 1'b0;
        else if (tag_open)
            return;
        else if (c == CHAR_AMP)
        begin
            held_text[0] = c;
            held_len     = 1;
        end
        else
            emit_char(c, 1'b1);
    endfunction

    // extend the held prefix by c; full match decodes, mismatch flushes literally
    function automatic void held_char(input logic [7:0] c);
        logic [7:0]  cand [ENT_MAX_LEN];
        int unsigned len;
        logic        hit;
        for (int k = 0; k < ENT_MAX_LEN; k++)
            cand[k] = (k < held_len) ? held_text[k] : 8'h00;
        cand[held_len] = c;
        len = held_len + 1;
        for (int e = 0; e < ENT_COUNT; e++)
        begin
            if (len <= ENT_LEN[e])
            begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (cand[k] != ENT_TEXT[e][k])
                        hit = 1'b0;
                if (hit)
                begin
                    if (len == ENT_LEN[e])
                    begin
                        held_len = 0;
                        emit_char(ENT_VALUE[e], 1'b1);
                    end
                    else
                    begin
                        held_text[len - 1] = c;
                        held_len = len;
                    end
                    return;
                end
            end
        end
        flush_held();
        plain_char(c);
    endfunction

    function automatic void strip_decode_predict(input logic [7:0] c, input logic has_ch,
                                                 input logic eoi);
        int unsigned base;
        text_out_t   r;
        base = text_out_q.size();
        if (has_ch)
        begin
            if (held_len > 0 && !tag_open)
                held_char(c);
            else
                plain_char(c);
        end
        if (eoi)
        begin
            flush_held();
            if (text_out_q.size() == base)
                emit_char(8'h00, 1'b0);
            r = text_out_q.pop_back();
            r.last = 1'b1;
            text_out_q.push_back(r);
            tag_open = 1'b0;
            held_len = 0;
        end
    endfunction

    // ---------------- stimulus ----------------

    // returns in the time step of the accepting edge
    task automatic send_item(input logic [7:0] c, input logic has_ch, input logic eoi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= has_ch;
        s_axis_tlast  <= eoi;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        if (has_ch || eoi)
            text_items++;
    endtask

    task automatic offer(input logic [7:0] c, input logic has_ch, input logic eoi);
        send_item(c, has_ch, eoi);
        strip_decode_predict(c, has_ch, eoi);
    endtask

    function automatic logic [7:0] text_char();
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic send_entity_prefix(input int unsigned e, input int unsigned n);
        for (int k = 0; k < n; k++)
            offer(ENT_TEXT[e][k], 1'b1, 1'b0);
    endtask

    // one chunk of text: mostly well-formed markup and entities, some noise
    task automatic send_segment();
        int unsigned pick;
        int unsigned e;
        int unsigned n;
        pick = $urandom_range(99);
        e    = $urandom_range(ENT_COUNT - 1);
        n    = $urandom_range(ENT_LEN[e] - 1, 1);
        if (pick < 25)
        begin
            repeat ($urandom_range(6, 1))
                offer(text_char(), 1'b1, 1'b0);
        end
        else if (pick < 45)
            send_entity_prefix(e, ENT_LEN[e]);
        else if (pick < 60)
        begin
            send_entity_prefix(e, n);
            case ($urandom_range(3))
                0: offer(text_char(), 1'b1, 1'b0);
                1: offer(CHAR_LT, 1'b1, 1'b0);
                2: offer(CHAR_AMP, 1'b1, 1'b0);
                default: offer(ENT_TEXT[(e + 1) % ENT_COUNT][n], 1'b1, 1'b0);
            endcase
        end
        else if (pick < 75)
        begin
            offer(CHAR_LT, 1'b1, 1'b0);
            repeat ($urandom_range(5, 0))
            begin
                if ($urandom_range(1))
                    offer(ENT_TEXT[e][$urandom_range(ENT_LEN[e] - 1)], 1'b1, 1'b0);
                else
                    offer(text_char(), 1'b1, 1'b0);
            end
            offer(CHAR_GT, 1'b1, 1'b0);
        end
        else if (pick < 87)
        begin
            case ($urandom_range(3))
                0: offer(8'($urandom_range(255)), 1'b0, 1'b1);
                1: offer(text_char(), 1'b1, 1'b1);
                2:
                begin
                    send_entity_prefix(e, n);
                    offer(8'($urandom_range(255)), 1'b0, 1'b1);
                end
                default:
                begin
                    offer(CHAR_LT, 1'b1, 1'b0);
                    offer(text_char(), 1'b1, 1'b1);
                end
            endcase
        end
        else if (pick < 94)
            offer(8'($urandom_range(255)), 1'b0, 1'b0);
        else
            offer((pick % 2) ? CHAR_LT : CHAR_GT, 1'b1, 1'b0);
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        int unsigned base;
        text_out_t   r;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        tag_open       = 1'b0;
        held_len       = 0;
        for (int k = 0; k < HOLD_MAX; k++)
            held_text[k] = 8'h00;
        fail_count     = 0;
        text_items     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].ch, directed_rows[i].has_ch, directed_rows[i].eoi);
            base = text_out_q.size();
            strip_decode_predict(directed_rows[i].ch, directed_rows[i].has_ch,
                                 directed_rows[i].eoi);
            if (directed_rows[i].typed)
            begin
                while (text_out_q.size() > base)
                    void'(text_out_q.pop_back());
                if (directed_rows[i].typed_out)
                begin
                    r.ch    = directed_rows[i].exp_ch;
                    r.valid = directed_rows[i].exp_valid;
                    r.last  = directed_rows[i].eoi;
                    text_out_q.push_back(r);
                end
            end
        end

        text_items = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // long output stall with the input running flat out
            if (ph == 0)
                hold_off_req = 1'b1;
            while (text_items < (ph + 1) * RANDOM_ITEMS / 5)
                send_segment();
        end
        s_axis_tvalid <= 1'b0;

        while (text_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (text_out_q.size() != 0)
        begin
            $error("%0d expected results never arrived", text_out_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ---------------- receiver ----------------

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // handshake is stable between edges; a transfer seen here completes on the next edge
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (text_out_q.size() == 0)
            begin
                $error("unexpected result: out_byte %h byte_valid %b end_of_text %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                next_exp = text_out_q.pop_front();
                if (m_axis_tdata !== next_exp.ch)
                begin
                    $error("out_byte: expected %h, got %h", next_exp.ch, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== next_exp.valid)
                begin
                    $error("byte_valid: expected %b, got %b", next_exp.valid, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== next_exp.last)
                begin
                    $error("end_of_text: expected %b, got %b", next_exp.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- html_tag_strip_entity_decode_top.f -----
+incdir+hw/rtl
hw/rtl/htsed_pkg.sv
hw/rtl/htsed_ctrl.sv
hw/rtl/htsed_dpath.sv
hw/rtl/html_tag_strip_entity_decode_top.sv
test/html_tag_strip_entity_decode_top_test.sv
